/* src/adaptive_colour_palette_model_assert.svh */
// assertion macros for the colour palette block
`ifndef ADAPTIVE_COLOUR_PALETTE_MODEL_ASSERT_SVH
`define ADAPTIVE_COLOUR_PALETTE_MODEL_ASSERT_SVH
`ifndef SYNTHESIS
`define ACPM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ACPM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ACPM_ASSERT_IMP(lbl, ante, cons, msg)
`define ACPM_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

/* src/acpm_pkg.sv */
`timescale 1ns / 1ps
package acpm_pkg;

  localparam int DEF_MAX_ENTRIES    = 256;
  localparam int DEF_MAX_COMPONENTS = 4;

  localparam int VAL_W   = 17;
  localparam int TOL_W   = 16;
  localparam int DIFF_W  = 18;
  localparam int CNT_W   = 16;
  localparam int MULT_W  = 4;
  localparam int SCALE_W = 8;
  localparam int FREQ_W  = 28;
  localparam int POS_W   = 9;
  localparam int NC_W    = 3;

  localparam logic [CNT_W-1:0]  COUNT_MAX  = 16'hFFFF;
  localparam logic [MULT_W-1:0] BOOST_BASE = 4'd8;

  typedef enum logic [1:0] {
    OP_INTEGRATE = 2'd0,
    OP_FIND      = 2'd1,
    OP_FETCH     = 2'd2,
    OP_FREQ      = 2'd3
  } op_t;

  localparam logic [1:0] REG_NUM_COMP   = 2'd0;
  localparam logic [1:0] REG_ESC_INIT   = 2'd1;
  localparam logic [1:0] REG_FREQ_SCALE = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CINC,
    S_HALVE,
    S_ADDR,
    S_DATA,
    S_MUL
  } state_t;

  // combined view of all component lanes
  typedef struct packed {
    logic              match;
    logic              sim;
    logic [MULT_W-1:0] mult;
  } merge_t;

endpackage

/* src/acpm_lane.sv */
`timescale 1ns / 1ps
module acpm_lane
  import acpm_pkg::*;
#(
  parameter int Depth = DEF_MAX_ENTRIES,
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                    clk,
  input  logic                    rd_en,
  input  logic [AW-1:0]           rd_addr,
  input  logic                    wr_en,
  input  logic [AW-1:0]           wr_addr,
  input  logic signed [VAL_W-1:0] wr_data,
  input  logic signed [VAL_W-1:0] x,
  input  logic [TOL_W-1:0]        tol,
  output logic signed [VAL_W-1:0] rd_data,
  output logic                    eq,
  output logic                    in_tol,
  output logic [DIFF_W-1:0]       absd
);

  logic signed [VAL_W-1:0]  mem [Depth];
  logic signed [DIFF_W-1:0] diff;

  // one component of every tuple
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // compare the fetched component with the request
  always_comb begin
    diff   = DIFF_W'(x) - DIFF_W'(rd_data);
    absd   = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    eq     = (rd_data == x);
    in_tol = (absd <= {tol, 2'b00});
  end

endmodule

/* src/acpm_merge.sv */
`timescale 1ns / 1ps
module acpm_merge
  import acpm_pkg::*;
#(
  parameter int Lanes = DEF_MAX_COMPONENTS
) (
  input  logic [Lanes-1:0]  mask,
  input  logic [Lanes-1:0]  eq,
  input  logic [Lanes-1:0]  in_tol,
  input  logic [DIFF_W-1:0] absd [Lanes],
  output merge_t            mg
);

  logic [DIFF_W-1:0] maxd;

  // and the lane flags, largest difference over compared lanes
  always_comb begin
    maxd = '0;
    for (int c = 0; c < Lanes; c++) begin
      if (mask[c] && absd[c] > maxd) begin
        maxd = absd[c];
      end
    end
    mg.match = &(eq | ~mask);
    mg.sim   = &(in_tol | ~mask);
    mg.mult  = (maxd < DIFF_W'(BOOST_BASE - 4'd1)) ? (BOOST_BASE - MULT_W'(maxd)) : 4'd1;
  end

endmodule

/* src/adaptive_colour_palette_model.sv */
`timescale 1ns / 1ps
// channel   | handshake          | payload
// request   | in_valid/in_ready  | operation, value_0..3, tol_0..3, position, boost_enable
// result    | out_valid/out_ready| found, position_out, value_out_0..3, frequency, ...
// config    | cfg_we             | cfg_index, cfg_data
// find/integrate scan the palette newest first, one tuple per cycle, and an integrate may
// then halve all counts in a further sweep (one count RAM read/write a cycle).
// fetch reads the stores and registers the result; frequency does two registered multiplies.
// one request at a time; a new request is taken once the previous result is taken.
// reset clears the count of tuples; stores need no clearing pass.
module adaptive_colour_palette_model
  import acpm_pkg::*;
#(
  parameter int MAX_ENTRIES    = DEF_MAX_ENTRIES,
  parameter int MAX_COMPONENTS = DEF_MAX_COMPONENTS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [CNT_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              operation,
  input  logic signed [VAL_W-1:0] value_0,
  input  logic signed [VAL_W-1:0] value_1,
  input  logic signed [VAL_W-1:0] value_2,
  input  logic signed [VAL_W-1:0] value_3,
  input  logic [TOL_W-1:0]        tol_0,
  input  logic [TOL_W-1:0]        tol_1,
  input  logic [TOL_W-1:0]        tol_2,
  input  logic [TOL_W-1:0]        tol_3,
  input  logic [POS_W-1:0]        position,
  input  logic                    boost_enable,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    found,
  output logic [POS_W-1:0]        position_out,
  output logic signed [VAL_W-1:0] value_out_0,
  output logic signed [VAL_W-1:0] value_out_1,
  output logic signed [VAL_W-1:0] value_out_2,
  output logic signed [VAL_W-1:0] value_out_3,
  output logic [FREQ_W-1:0]       frequency,
  output logic [POS_W-1:0]        entry_total_out,
  output logic                    full_res
);

  localparam int L  = MAX_COMPONENTS;
  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int TW = $clog2(MAX_ENTRIES + 1);
  localparam int PW = ((TW > POS_W) ? TW : POS_W) + 1;
  localparam int HW = ((CNT_W > TW) ? CNT_W : TW) + 1;
  localparam int P1W = CNT_W + MULT_W;

  // configuration
  logic [NC_W-1:0]    nc_cfg, nc_cfg_next;
  logic [SCALE_W-1:0] scale, scale_next;
  logic [NC_W-1:0]    nc_eff;
  logic [L-1:0]       mask;

  // control and captured request
  state_t             state, state_next;
  op_t                op_r, op_r_next;
  logic signed [VAL_W-1:0] x_r [L];
  logic signed [VAL_W-1:0] x_r_next [L];
  logic [TOL_W-1:0]   tol_r [L];
  logic [TOL_W-1:0]   tol_r_next [L];
  logic [POS_W-1:0]   pos_r, pos_r_next;
  logic               boost_r, boost_r_next;
  logic signed [VAL_W-1:0] value_in [4];
  logic [TOL_W-1:0]   tol_in [4];

  // scan bookkeeping
  logic [AW-1:0]      scan_k, scan_k_next;
  logic [TW-1:0]      scan_left, scan_left_next;
  logic               pend, pend_next;
  logic [AW-1:0]      pend_k, pend_k_next;
  logic [AW-1:0]      hit_k, hit_k_next;
  logic               fv, fv_next;

  // palette state
  logic [TW-1:0]      entry_total, entry_total_next;
  logic [CNT_W-1:0]   escape_count, escape_count_next;

  // result registers
  logic               out_valid_next;
  logic               res_found, res_found_next;
  logic [POS_W-1:0]   res_pos, res_pos_next;
  logic signed [VAL_W-1:0] res_val [4];
  logic signed [VAL_W-1:0] res_val_next [4];
  logic [FREQ_W-1:0]  res_freq, res_freq_next;
  logic               res_full, res_full_next;
  logic [P1W-1:0]     prod1, prod1_next;

  // lane ports
  logic               lane_rd_en;
  logic [AW-1:0]      lane_rd_addr;
  logic               lane_we;
  logic [AW-1:0]      lane_wa;
  logic signed [VAL_W-1:0] lane_wd [L];
  logic signed [VAL_W-1:0] lane_rd [L];
  logic [L-1:0]       lane_eq;
  logic [L-1:0]       lane_ok;
  logic [DIFF_W-1:0]  lane_d [L];
  merge_t             mg;

  // count memory ports
  logic [CNT_W-1:0]   cnt_mem [MAX_ENTRIES];
  logic               cnt_rd_en;
  logic [AW-1:0]      cnt_rd_addr;
  logic [CNT_W-1:0]   cnt_rd;
  logic               cnt_we;
  logic [AW-1:0]      cnt_wa;
  logic [CNT_W-1:0]   cnt_wd;

  // helpers
  logic               accept;
  logic [PW-1:0]      pos_w, tot_w, addr_w;
  logic [CNT_W-1:0]   cnt_inc;
  logic [HW-1:0]      thresh;

  assign value_in[0] = value_0;
  assign value_in[1] = value_1;
  assign value_in[2] = value_2;
  assign value_in[3] = value_3;
  assign tol_in[0]   = tol_0;
  assign tol_in[1]   = tol_1;
  assign tol_in[2]   = tol_2;
  assign tol_in[3]   = tol_3;

  assign in_ready = (state == S_IDLE) && !out_valid;
  assign accept   = in_valid && in_ready;

  // clamp the component count
  always_comb begin
    if (nc_cfg == '0) begin
      nc_eff = NC_W'(1);
    end else if (32'(nc_cfg) > L) begin
      nc_eff = NC_W'(L);
    end else begin
      nc_eff = nc_cfg;
    end
    for (int c = 0; c < L; c++) begin
      mask[c] = (c < 32'(nc_eff));
    end
  end

  // component lanes
  for (genvar g = 0; g < L; g++) begin : g_lane
    assign lane_wd[g] = mask[g] ? x_r[g] : '0;
    acpm_lane #(.Depth(MAX_ENTRIES)) u_lane (
      .clk    (clk),
      .rd_en  (lane_rd_en),
      .rd_addr(lane_rd_addr),
      .wr_en  (lane_we),
      .wr_addr(lane_wa),
      .wr_data(lane_wd[g]),
      .x      (x_r[g]),
      .tol    (tol_r[g]),
      .rd_data(lane_rd[g]),
      .eq     (lane_eq[g]),
      .in_tol (lane_ok[g]),
      .absd   (lane_d[g])
    );
  end

  acpm_merge #(.Lanes(L)) u_merge (
    .mask  (mask),
    .eq    (lane_eq),
    .in_tol(lane_ok),
    .absd  (lane_d),
    .mg    (mg)
  );

  // count memory
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    if (cnt_rd_en) begin
      cnt_rd <= cnt_mem[cnt_rd_addr];
    end
  end

  // address and threshold arithmetic
  always_comb begin
    pos_w   = PW'(pos_r);
    tot_w   = PW'(entry_total);
    addr_w  = tot_w - pos_w + ((op_r == OP_FREQ) ? PW'(1) : PW'(0));
    cnt_inc = (cnt_rd == COUNT_MAX) ? cnt_rd : cnt_rd + 1'b1;
    thresh  = HW'(4) + HW'(entry_total >> 2);
  end

  // state register and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      pend         <= 1'b0;
      entry_total  <= '0;
      escape_count <= CNT_W'(1);
      nc_cfg       <= NC_W'(3);
      scale        <= SCALE_W'(1);
    end else begin
      state        <= state_next;
      out_valid    <= out_valid_next;
      pend         <= pend_next;
      entry_total  <= entry_total_next;
      escape_count <= escape_count_next;
      nc_cfg       <= nc_cfg_next;
      scale        <= scale_next;
    end
    op_r      <= op_r_next;
    x_r       <= x_r_next;
    tol_r     <= tol_r_next;
    pos_r     <= pos_r_next;
    boost_r   <= boost_r_next;
    scan_k    <= scan_k_next;
    scan_left <= scan_left_next;
    pend_k    <= pend_k_next;
    hit_k     <= hit_k_next;
    fv        <= fv_next;
    prod1     <= prod1_next;
    res_found <= res_found_next;
    res_pos   <= res_pos_next;
    res_val   <= res_val_next;
    res_freq  <= res_freq_next;
    res_full  <= res_full_next;
  end

  // next state and memory controls
  always_comb begin
    state_next        = state;
    out_valid_next    = out_valid;
    op_r_next         = op_r;
    x_r_next          = x_r;
    tol_r_next        = tol_r;
    pos_r_next        = pos_r;
    boost_r_next      = boost_r;
    scan_k_next       = scan_k;
    scan_left_next    = scan_left;
    pend_next         = pend;
    pend_k_next       = pend_k;
    hit_k_next        = hit_k;
    fv_next           = fv;
    prod1_next        = prod1;
    entry_total_next  = entry_total;
    escape_count_next = escape_count;
    nc_cfg_next       = nc_cfg;
    scale_next        = scale;
    res_found_next    = res_found;
    res_pos_next      = res_pos;
    res_val_next      = res_val;
    res_freq_next     = res_freq;
    res_full_next     = res_full;
    lane_rd_en        = 1'b0;
    lane_rd_addr      = scan_k;
    lane_we           = 1'b0;
    lane_wa           = entry_total[AW-1:0];
    cnt_rd_en         = 1'b0;
    cnt_rd_addr       = scan_k;
    cnt_we            = 1'b0;
    cnt_wa            = hit_k;
    cnt_wd            = cnt_inc;

    // register writes
    if (cfg_we) begin
      case (cfg_index)
        REG_NUM_COMP:   nc_cfg_next = cfg_data[NC_W-1:0];
        REG_ESC_INIT:   escape_count_next = cfg_data;
        REG_FREQ_SCALE: scale_next = cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end

    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end

    case (state)
      S_IDLE: begin
        if (accept) begin
          op_r_next    = op_t'(operation);
          pos_r_next   = position;
          boost_r_next = boost_enable;
          for (int c = 0; c < L; c++) begin
            x_r_next[c]   = value_in[c];
            tol_r_next[c] = tol_in[c];
          end
          res_found_next = 1'b0;
          res_pos_next   = '0;
          res_freq_next  = '0;
          res_full_next  = 1'b0;
          for (int c = 0; c < 4; c++) begin
            res_val_next[c] = '0;
          end
          scan_k_next    = AW'(entry_total - 1'b1);
          scan_left_next = entry_total;
          pend_next      = 1'b0;
          if (op_t'(operation) == OP_INTEGRATE || op_t'(operation) == OP_FIND) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_ADDR;
          end
        end
      end

      // newest first, one tuple a cycle
      S_SCAN: begin
        lane_rd_en  = (scan_left != '0);
        pend_next   = (scan_left != '0);
        pend_k_next = scan_k;
        if (scan_left != '0) begin
          scan_k_next    = scan_k - 1'b1;
          scan_left_next = scan_left - 1'b1;
        end
        if (pend && mg.match) begin
          pend_next      = 1'b0;
          hit_k_next     = pend_k;
          res_found_next = 1'b1;
          res_pos_next   = POS_W'(entry_total - TW'(pend_k));
          if (op_r == OP_INTEGRATE) begin
            cnt_rd_en   = 1'b1;
            cnt_rd_addr = pend_k;
            state_next  = S_CINC;
          end else begin
            out_valid_next = 1'b1;
            state_next     = S_IDLE;
          end
        end else if (!pend && scan_left == '0) begin
          if (op_r == OP_INTEGRATE) begin
            if (entry_total >= TW'(MAX_ENTRIES)) begin
              res_full_next = 1'b1;
            end else begin
              // new tuple goes after the others, seen as position one
              lane_we          = 1'b1;
              cnt_we           = 1'b1;
              cnt_wa           = entry_total[AW-1:0];
              cnt_wd           = CNT_W'(1);
              entry_total_next = entry_total + 1'b1;
            end
          end
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end

      // bump the matched count, maybe start halving
      S_CINC: begin
        cnt_we = 1'b1;
        if (HW'(cnt_inc) > thresh) begin
          escape_count_next = escape_count >> 1;
          scan_k_next       = '0;
          scan_left_next    = entry_total;
          pend_next         = 1'b0;
          state_next        = S_HALVE;
        end else begin
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end

      // read-modify-write sweep over all counts
      S_HALVE: begin
        cnt_rd_en   = (scan_left != '0);
        pend_next   = (scan_left != '0);
        pend_k_next = scan_k;
        if (scan_left != '0) begin
          scan_k_next    = scan_k + 1'b1;
          scan_left_next = scan_left - 1'b1;
        end
        if (pend) begin
          cnt_we = 1'b1;
          cnt_wa = pend_k;
          cnt_wd = cnt_rd >> 1;
        end else if (scan_left == '0) begin
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end

      // fetch and frequency read
      S_ADDR: begin
        lane_rd_en   = 1'b1;
        lane_rd_addr = addr_w[AW-1:0];
        cnt_rd_en    = 1'b1;
        cnt_rd_addr  = addr_w[AW-1:0];
        if (op_r == OP_FETCH) begin
          fv_next = (pos_w != '0) && (pos_w <= tot_w);
        end else begin
          fv_next = (pos_w <= tot_w + 1'b1);
        end
        state_next = S_DATA;
      end

      S_DATA: begin
        res_found_next = fv;
        if (op_r == OP_FETCH) begin
          for (int c = 0; c < L; c++) begin
            res_val_next[c] = (fv && mask[c]) ? lane_rd[c] : '0;
          end
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end else begin
          if (pos_w == PW'(1)) begin
            prod1_next = P1W'(escape_count);
          end else if (fv && pos_w != '0) begin
            if (boost_r && mg.sim) begin
              prod1_next = P1W'(cnt_rd) * P1W'(mg.mult);
            end else begin
              prod1_next = P1W'(cnt_rd);
            end
          end else begin
            prod1_next = '0;
          end
          state_next = S_MUL;
        end
      end

      S_MUL: begin
        res_freq_next  = FREQ_W'(prod1) * FREQ_W'(scale);
        out_valid_next = 1'b1;
        state_next     = S_IDLE;
      end

      default: state_next = S_IDLE;
    endcase
  end

  assign found           = res_found;
  assign position_out    = res_pos;
  assign value_out_0     = res_val[0];
  assign value_out_1     = res_val[1];
  assign value_out_2     = res_val[2];
  assign value_out_3     = res_val[3];
  assign frequency       = res_freq;
  assign entry_total_out = POS_W'(entry_total);
  assign full_res        = res_full;

`include "adaptive_colour_palette_model_assert.svh"

  `ACPM_ASSERT_IMP(a_total_bound, 1'b1, entry_total <= TW'(MAX_ENTRIES), "palette overfilled")
  `ACPM_ASSERT_IMP(a_busy_no_result, state != S_IDLE, !out_valid, "result shown while busy")
  `ACPM_ASSERT_IMP(a_insert_room, lane_we, entry_total < TW'(MAX_ENTRIES), "insert into full palette")
  `ACPM_ASSERT_NXT(a_insert_grows, lane_we, entry_total == TW'($past(entry_total) + 1'b1), "insert lost")

endmodule
